/* rtl/assert_macros.svh */
// Assertion macros used by the union-find cycle edge filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: cond -> expr");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: cond => expr");

`endif

/* rtl/ufcef_pkg.sv */
// Package with the constants and widths of the union-find cycle edge filter.
`timescale 1ns / 1ps

package ufcef_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int RANK_W       = 4;
  localparam int WEIGHT_W     = 16;
  localparam int SUM_W        = 32;

  localparam logic [RANK_W-1:0] RANK_LIMIT = {RANK_W{1'b1}};

  localparam int IN_FIELDS_W  = 2 * VIDX_W + WEIGHT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + SUM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(MAX_VERTICES);

endpackage

/* rtl/union_find_cycle_edge_filter.sv */
// Top level of the union-find cycle edge filter with its parent and rank memories.
//
//  channel | direction | transfer when           | contents
//  --------+-----------+-------------------------+-----------------------------------------
//  s_      | in        | s_tvalid & s_tready     | edge: tdata a, b, weight; tlast last edge
//  m_      | out       | m_tvalid & m_tready     | removed flag, total; tlast graph end
//  cfg_    | in        | cfg_valid & cfg_ready   | vertex_count
//
// One edge at a time: the edge is taken while idle, then for each endpoint a first parent
// memory read and a walk up to its root, then a second walk that compresses the path;
// two different roots are then linked by rank in the RANKA, RANKB and UNION states.
// After reset and after every last edge, a clearing pass rewrites both memories before
// the next edge is taken. A stalled output holds one result while the next edge is
// processed; that edge then waits for the output register to free up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module union_find_cycle_edge_filter
  import ufcef_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // end_vertex_a, end_vertex_b, edge_weight, zero padding
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // edge_removed, removed_total, zero padding
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_COMP  = 4'd5;
  localparam logic [3:0] S_RANKA = 4'd6;
  localparam logic [3:0] S_RANKB = 4'd7;
  localparam logic [3:0] S_UNION = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [VIDX_W-1:0] parent_mem [MAX_VERTICES];
  logic [RANK_W-1:0] rank_mem   [MAX_VERTICES];

  logic [3:0]              state;
  logic [VIDX_W-1:0]       clr_idx;
  logic [CNT_W-1:0]        vertex_count;
  logic signed [SUM_W-1:0] removed_sum;

  logic [VIDX_W-1:0]          a_q;
  logic [VIDX_W-1:0]          b_q;
  logic signed [WEIGHT_W-1:0] w_q;
  logic                       last_q;
  logic                       removed_q;
  logic                       side;
  logic [VIDX_W-1:0]          cur;
  logic [VIDX_W-1:0]          root;
  logic [VIDX_W-1:0]          root_a;
  logic [RANK_W-1:0]          rank_a;

  logic                    out_removed;
  logic signed [SUM_W-1:0] out_total;
  logic                    out_last;

  logic [VIDX_W-1:0] par_raddr;
  logic [VIDX_W-1:0] par_q;
  logic              par_we;
  logic [VIDX_W-1:0] par_waddr;
  logic [VIDX_W-1:0] par_wdata;
  logic [VIDX_W-1:0] rank_raddr;
  logic [RANK_W-1:0] rank_q;
  logic              rank_we;
  logic [VIDX_W-1:0] rank_waddr;
  logic [RANK_W-1:0] rank_wdata;

  logic [VIDX_W-1:0]          in_a;
  logic [VIDX_W-1:0]          in_b;
  logic signed [WEIGHT_W-1:0] in_w;
  logic [CNT_W-1:0]           eff_count;
  logic                       in_range;
  logic                       out_free;
  logic                       out_load;
  logic                       clr_done;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_next;

  assign in_a = s_tdata[VIDX_W-1:0];
  assign in_b = s_tdata[2*VIDX_W-1:VIDX_W];
  assign in_w = s_tdata[IN_FIELDS_W-1:2*VIDX_W];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == S_DONE) && out_free;
  assign clr_done  = (clr_idx == VIDX_W'(MAX_VERTICES - 1));

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_total, out_removed};
  assign m_tlast = out_last;

  always_comb begin
    if (vertex_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
      eff_count = CNT_W'(MAX_VERTICES);
    end else begin
      eff_count = vertex_count;
    end
    in_range = ({1'b0, in_a} < eff_count) && ({1'b0, in_b} < eff_count);
  end

  always_comb begin
    sum_wide = {removed_sum[SUM_W-1], removed_sum} + (SUM_W+1)'(w_q);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    par_raddr  = cur;
    par_we     = 1'b0;
    par_waddr  = cur;
    par_wdata  = root;
    rank_raddr = root_a;
    rank_we    = 1'b0;
    rank_waddr = root_a;
    rank_wdata = '0;
    case (state)
      S_CLR: begin
        par_we     = 1'b1;
        par_waddr  = clr_idx;
        par_wdata  = clr_idx;
        rank_we    = 1'b1;
        rank_waddr = clr_idx;
      end
      S_WALK: begin
        par_raddr = par_q;
      end
      S_COMP: begin
        par_raddr = par_q;
        par_we    = (cur != root);
      end
      S_RANKB: begin
        rank_raddr = root;
      end
      S_UNION: begin
        par_we = 1'b1;
        if (rank_a < rank_q) begin
          par_waddr = root_a;
          par_wdata = root;
        end else begin
          par_waddr = root;
          par_wdata = root_a;
        end
        if (rank_a == rank_q && rank_a != RANK_LIMIT) begin
          rank_we    = 1'b1;
          rank_wdata = rank_a + RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_q <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_q <= rank_mem[rank_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      vertex_count <= VERTEX_COUNT_RESET;
      removed_sum  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + VIDX_W'(1);
          if (clr_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            a_q       <= in_a;
            b_q       <= in_b;
            w_q       <= in_w;
            last_q    <= s_tlast;
            removed_q <= 1'b0;
            side      <= 1'b0;
            cur       <= in_a;
            state     <= in_range ? S_FRD : S_DONE;
          end
        end
        S_FRD: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (par_q == cur) begin
            root  <= cur;
            cur   <= side ? b_q : a_q;
            state <= S_CRD;
          end else begin
            cur <= par_q;
          end
        end
        S_CRD: begin
          state <= S_COMP;
        end
        S_COMP: begin
          if (cur != root) begin
            cur <= par_q;
          end else if (!side) begin
            root_a <= root;
            side   <= 1'b1;
            cur    <= b_q;
            state  <= S_FRD;
          end else if (root_a == root) begin
            removed_q   <= 1'b1;
            removed_sum <= sum_next;
            state       <= S_DONE;
          end else begin
            state <= S_RANKA;
          end
        end
        S_RANKA: begin
          state <= S_RANKB;
        end
        S_RANKB: begin
          rank_a <= rank_q;
          state  <= S_UNION;
        end
        S_UNION: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_removed <= removed_q;
            out_total   <= removed_sum;
            out_last    <= last_q;
            if (last_q) begin
              removed_sum <= '0;
              clr_idx     <= '0;
              state       <= S_CLR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_last_starts_clear, clk, rst, out_load && last_q, (state == S_CLR) && m_tvalid)
  `ASSERT_NEXT(a_last_clears_sum, clk, rst, out_load && last_q, removed_sum == '0)
  `ASSERT_NEXT(a_clear_ends_idle, clk, rst, (state == S_CLR) && clr_done, state == S_IDLE)
  `ASSERT_IMPLIES(a_union_links_roots, clk, rst, state == S_UNION, par_waddr != par_wdata)
  `ASSERT_IMPLIES(a_no_compress_root, clk, rst, (state == S_COMP) && par_we, par_waddr != root)

endmodule

/* sim/cycle_edge_checker.sv */
// Checker that predicts and compares every result of the union-find cycle edge filter.
`timescale 1ns / 1ps

module cycle_edge_checker
  import ufcef_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data,
  output int                     outstanding,
  output int                     mismatches
);

  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< (SUM_W - 1));

  typedef struct packed {
    logic             edge_removed;
    logic [SUM_W-1:0] removed_total;
    logic             graph_end;
  } edge_verdict_t;

  logic [VIDX_W-1:0]       parent_of [MAX_VERTICES];
  logic [RANK_W-1:0]       rank_of [MAX_VERTICES];
  logic signed [SUM_W-1:0] cycle_weight_sum;
  logic [CNT_W-1:0]        vertex_limit;
  edge_verdict_t           verdicts_due [$];

  function automatic void clear_forest();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      parent_of[i] = VIDX_W'(i);
      rank_of[i] = '0;
    end
    cycle_weight_sum = '0;
  endfunction

  function automatic int usable_vertices();
    if (vertex_limit == 0) return 1;
    if (vertex_limit > MAX_VERTICES) return MAX_VERTICES;
    return int'(vertex_limit);
  endfunction

  // Walk up to the root, then point every node on the path straight at it.
  function automatic logic [VIDX_W-1:0] find_root(input logic [VIDX_W-1:0] v);
    logic [VIDX_W-1:0] root;
    logic [VIDX_W-1:0] next;
    root = v;
    for (int n = 0; n < MAX_VERTICES && parent_of[root] != root; n++)
      root = parent_of[root];
    for (int n = 0; n < MAX_VERTICES && v != root; n++) begin
      next = parent_of[v];
      parent_of[v] = root;
      v = next;
    end
    return root;
  endfunction

  function automatic edge_verdict_t predict_edge(input logic [VIDX_W-1:0] a,
                                                 input logic [VIDX_W-1:0] b,
                                                 input logic signed [WEIGHT_W-1:0] w,
                                                 input logic last);
    edge_verdict_t     verdict;
    logic [VIDX_W-1:0] ra;
    logic [VIDX_W-1:0] rb;
    longint            total;
    int                span;
    span = usable_vertices();
    verdict.edge_removed = 1'b0;
    if (int'(a) < span && int'(b) < span) begin
      ra = find_root(a);
      rb = find_root(b);
      if (ra == rb) begin
        total = longint'(cycle_weight_sum) + longint'(w);
        if (total > SUM_MAX) total = SUM_MAX;
        if (total < SUM_MIN) total = SUM_MIN;
        cycle_weight_sum = SUM_W'(total);
        verdict.edge_removed = 1'b1;
      end else if (rank_of[ra] < rank_of[rb]) begin
        parent_of[ra] = rb;
      end else if (rank_of[ra] > rank_of[rb]) begin
        parent_of[rb] = ra;
      end else begin
        parent_of[rb] = ra;
        if (rank_of[ra] < RANK_LIMIT) rank_of[ra] = rank_of[ra] + RANK_W'(1);
      end
    end
    verdict.removed_total = cycle_weight_sum;
    verdict.graph_end = last;
    if (last) clear_forest();
    return verdict;
  endfunction

  always @(posedge clk) begin : watch
    edge_verdict_t seen;
    edge_verdict_t due;
    if (rst) begin
      verdicts_due.delete();
      vertex_limit = VERTEX_COUNT_RESET;
      mismatches = 0;
      clear_forest();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.edge_removed = m_tdata[0];
        seen.removed_total = m_tdata[SUM_W:1];
        seen.graph_end = m_tlast;
        if (verdicts_due.size() == 0) begin
          $error("result transfer with no edge outstanding");
          mismatches++;
        end else begin
          due = verdicts_due.pop_front();
          if (seen.edge_removed !== due.edge_removed) begin
            $error("edge_removed: expected %0d, got %0d", due.edge_removed,
                   seen.edge_removed);
            mismatches++;
          end
          if (seen.removed_total !== due.removed_total) begin
            $error("removed_total: expected %0d, got %0d", $signed(due.removed_total),
                   $signed(seen.removed_total));
            mismatches++;
          end
          if (seen.graph_end !== due.graph_end) begin
            $error("graph_end: expected %0d, got %0d", due.graph_end, seen.graph_end);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        verdicts_due = {verdicts_due, predict_edge(s_tdata[VIDX_W-1:0],
                                                   s_tdata[2*VIDX_W-1:VIDX_W],
                                                   s_tdata[IN_FIELDS_W-1:2*VIDX_W],
                                                   s_tlast)};
      if (cfg_valid && cfg_ready) vertex_limit = cfg_data;
    end
    outstanding = verdicts_due.size();
  end

endmodule

/* sim/tb_union_find_cycle_edge_filter.sv */
// Testbench top that drives edges and vertex counts into the cycle edge filter.
`timescale 1ns / 1ps

module tb_union_find_cycle_edge_filter;
  import ufcef_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data = '0;

  int   outstanding;
  int   mismatches;
  int   send_gap_pct = 0;
  int   stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   span = MAX_VERTICES;
  int   edges_counted = 0;

  union_find_cycle_edge_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cycle_edge_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("union_find_cycle_edge_filter verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_edge(input int a, input int b, input int w, input int last);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= IN_TDATA_W'({WEIGHT_W'(w), VIDX_W'(b), VIDX_W'(a)});
    s_tlast <= (last != 0);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_vertex_count(input int count);
    settle_results();
    cfg_data <= CNT_W'(count);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (count == 0) span = 1;
    else if (count > MAX_VERTICES) span = MAX_VERTICES;
    else span = count;
  endtask

  // Mostly descending weights with random endpoints, some self loops,
  // some endpoints past the vertex count and some weights out of order.
  task automatic run_graph(input int edges, input int closing);
    int a;
    int b;
    int w;
    int w_run;
    int kind;
    w_run = 32767 - int'($urandom_range(20000));
    for (int i = 0; i < edges; i++) begin
      kind = int'($urandom_range(99));
      a = int'($urandom_range(span - 1));
      b = int'($urandom_range(span - 1));
      if (kind < 8 && span < MAX_VERTICES) begin
        if (kind < 4) a = int'($urandom_range(MAX_VERTICES - 1, span));
        else b = int'($urandom_range(MAX_VERTICES - 1, span));
      end else if (kind < 14) begin
        b = a;
      end
      if ($urandom_range(9) == 0) begin
        w = int'($urandom_range(65535)) - 32768;
      end else begin
        w_run = w_run - int'($urandom_range(600));
        if (w_run < -32768) w_run = -32768;
        w = w_run;
      end
      edges_counted++;
      send_edge(a, b, w, (closing != 0) && (i == edges - 1));
    end
  endtask

  initial begin
    int graph_no;
    int pick;
    int count;
    int edges;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_vertex_count(4);
    send_edge(0, 1, 32767, 0);
    send_edge(1, 2, 100, 0);
    send_edge(2, 0, 50, 0);
    send_edge(3, 3, -32768, 0);
    send_edge(4, 0, 5, 0);
    send_edge(0, 1023, -1, 0);
    send_edge(1023, 1023, 0, 0);
    send_edge(3, 1, -1, 0);
    send_edge(0, 3, -2, 1);
    write_vertex_count(0);
    send_edge(0, 0, 7, 0);
    send_edge(0, 1, 7, 0);
    send_edge(1, 0, -7, 1);
    write_vertex_count(2047);
    send_edge(1023, 0, 21845, 0);
    send_edge(682, 341, -21846, 0);
    send_edge(341, 1023, 1000, 0);
    send_edge(682, 0, 900, 0);
    send_edge(1023, 1023, -500, 1);
    write_vertex_count(1025);
    send_edge(512, 1023, 0, 0);
    send_edge(1023, 512, -32768, 1);
    write_vertex_count(3);
    send_edge(0, 2, 300, 0);
    write_vertex_count(8);
    send_edge(7, 0, 200, 0);
    send_edge(2, 7, 100, 1);

    graph_no = 0;
    while (edges_counted < 1120) begin
      case (graph_no % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_gap_pct = 55;
          stall_pct <= 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct <= 55;
        end
        default: begin
          send_gap_pct = 15;
          stall_pct <= 15;
        end
      endcase
      pick = int'($urandom_range(99));
      if (pick < 60) count = int'($urandom_range(24, 2));
      else if (pick < 75) count = int'($urandom_range(200, 25));
      else if (pick < 85) count = MAX_VERTICES;
      else if (pick < 92) count = int'($urandom_range(2047, 1025));
      else if (pick < 96) count = 0;
      else count = 1;
      if (graph_no == 0 || $urandom_range(3) != 0) write_vertex_count(count);
      if (span <= 24) edges = int'($urandom_range(3 * span + 4, 4));
      else edges = int'($urandom_range(60, 10));
      if (graph_no == 6) begin
        hold_request <= 1'b1;
        edges = 60;
      end
      run_graph(edges, $urandom_range(4) != 0);
      graph_no++;
    end

    settle_results();
    repeat (100) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("union_find_cycle_edge_filter verification clean");
    end else begin
      $display("union_find_cycle_edge_filter verification failed");
    end
    $finish;
  end

endmodule
